@@ rtl/core/sbl_pkg.sv @@
// shared types and constants for the segment line of sight block
`default_nettype none
package sbl_pkg;

  localparam int MAX_WALLS  = 64;
  localparam int WALL_AW    = 6;
  localparam int COORD_BITS = 32;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int FRAC_BITS  = 16;
  localparam int DVD_BITS   = DIFF_BITS + FRAC_BITS;
  localparam int T_BITS     = 64;
  localparam int CNT_BITS   = 7;
  localparam int LIM_BITS   = 17;
  localparam int WALL_BITS  = 6 * COORD_BITS;
  localparam int STEP_BITS  = 6;

  localparam logic signed [T_BITS-1:0] T_POS_INF = {1'b0, {(T_BITS-1){1'b1}}};
  localparam logic signed [T_BITS-1:0] T_NEG_INF = -T_POS_INF;

  // configuration register indexes
  localparam logic [1:0] CFG_WALL_COUNT = 2'd0;
  localparam logic [1:0] CFG_NEAR_LIMIT = 2'd1;
  localparam logic [1:0] CFG_FAR_LIMIT  = 2'd2;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_AXIS,
    ST_DLO,
    ST_DHI,
    ST_COMB,
    ST_FIN,
    ST_DONE
  } sbl_state_t;

endpackage
`default_nettype wire

@@ rtl/core/segment_box_line_of_sight.sv @@
// top level: wall box table and slab test sequencer for segment line of sight
// Usage:
//   s_* carries input items: s_tuser is the kind (0 load, 1 query), s_tdata
//   holds the slot and the two corners or end points. A load writes one wall
//   in the cycle it is accepted and gives no result. A query gives one result
//   item on m_* (line clear flag and first blocking wall).
//   cfg_* writes wall_count, near_limit and far_limit; it is always ready.
// Sequence:
//   each tested wall takes a table read state plus, per axis, a setup
//   state, two divisions on the shared bit-serial divider and a combine
//   state, then a final check state; an axis with zero direction needs
//   only the setup state and a rejected wall stops early.
//   the result is registered after the last tested wall, and no new item
//   is taken until the sequencer is back in idle.
//   s_tready is high only while the sequencer is idle, also while an earlier
//   result still waits in the output register.
// Reset clears the sequencer, the output valid and the registers
// (wall_count 0, near_limit 0, far_limit 65535); the wall table is not
// cleared. When the receiver stalls, a finished query holds until taken.
`default_nettype none
module segment_box_line_of_sight (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [5:0] wall_slot, [37:6] a_x, [69:38] a_y, [101:70] a_z,
  // [133:102] b_x, [165:134] b_y, [197:166] b_z, [199:198] zero
  input  wire logic [199:0] s_tdata,
  // [0] kind
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [0] line_clear, [6:1] blocking_wall, [7] zero
  output logic [7:0]        m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [16:0]  cfg_data
);
  import sbl_pkg::*;

  sbl_state_t state, state_next;

  logic [CNT_BITS-1:0] wall_count;
  logic [LIM_BITS-1:0] near_limit;
  logic [LIM_BITS-1:0] far_limit;

  logic signed [COORD_BITS-1:0] org [3];
  logic signed [DIFF_BITS-1:0]  dir [3];
  logic [CNT_BITS-1:0]          num_walls;
  logic [WALL_AW-1:0]           wall;
  logic [1:0]                   ax;
  logic signed [DIFF_BITS-1:0]  n_far;
  logic signed [T_BITS-1:0]     t_lo, t_hi, run_lo, run_hi;
  logic                         res_clear;
  logic [WALL_AW-1:0]           res_wall;

  logic [WALL_BITS-1:0] wall_data;
  logic                 in_acc;
  logic                 ram_we;

  logic signed [COORD_BITS-1:0] ax_o, ax_mn, ax_mx, near_f, far_f;
  logic signed [DIFF_BITS-1:0]  ax_d, n_lo, n_hi, div_n;
  logic [DIFF_BITS-1:0]         d_mag, n_mag;
  logic                         in_slab, rej, hit, last_wall;
  logic                         div_start, div_neg, div_done;
  logic signed [T_BITS-1:0]     div_q;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign ram_we    = in_acc && (s_tuser == KIND_LOAD);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_count <= '0;
      near_limit <= '0;
      far_limit  <= LIM_BITS'(65535);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WALL_COUNT: wall_count <= cfg_data[CNT_BITS-1:0];
        CFG_NEAR_LIMIT: near_limit <= cfg_data;
        CFG_FAR_LIMIT:  far_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // wall table: {max_z, max_y, max_x, min_z, min_y, min_x}
  sbl_ram #(
    .WIDTH(WALL_BITS),
    .DEPTH(MAX_WALLS)
  ) u_walls (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(s_tdata[5:0]),
    .wr_data({s_tdata[197:166], s_tdata[165:134], s_tdata[133:102],
              s_tdata[101:70], s_tdata[69:38], s_tdata[37:6]}),
    .rd_addr(wall),
    .rd_data(wall_data)
  );

  // per-axis operand selection
  always_comb begin
    unique case (ax)
      2'd0: begin
        ax_mn = wall_data[31:0];
        ax_mx = wall_data[127:96];
      end
      2'd1: begin
        ax_mn = wall_data[63:32];
        ax_mx = wall_data[159:128];
      end
      default: begin
        ax_mn = wall_data[95:64];
        ax_mx = wall_data[191:160];
      end
    endcase
    ax_o   = (ax == 2'd0) ? org[0] : (ax == 2'd1) ? org[1] : org[2];
    ax_d   = (ax == 2'd0) ? dir[0] : (ax == 2'd1) ? dir[1] : dir[2];
    in_slab = (ax_mn <= ax_o) && (ax_o <= ax_mx);
    near_f = ax_d[DIFF_BITS-1] ? ax_mx : ax_mn;
    far_f  = ax_d[DIFF_BITS-1] ? ax_mn : ax_mx;
    n_lo   = DIFF_BITS'(near_f) - DIFF_BITS'(ax_o);
    n_hi   = DIFF_BITS'(far_f) - DIFF_BITS'(ax_o);
    d_mag  = ax_d[DIFF_BITS-1] ? DIFF_BITS'(-ax_d) : DIFF_BITS'(ax_d);
    div_n  = (state == ST_AXIS) ? n_lo : n_far;
    n_mag  = div_n[DIFF_BITS-1] ? DIFF_BITS'(-div_n) : DIFF_BITS'(div_n);
    div_neg = div_n[DIFF_BITS-1] ^ ax_d[DIFF_BITS-1];
    rej    = (run_lo > t_hi) || (t_lo > run_hi);
    hit    = (run_lo < $signed(T_BITS'(far_limit)))
          && (run_hi > $signed(T_BITS'(near_limit)));
    last_wall = (CNT_BITS'(wall) + 1'b1) >= num_walls;
  end

  // shared divider
  sbl_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (n_mag),
    .den  (d_mag),
    .neg  (div_neg),
    .done (div_done),
    .quot (div_q)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && s_tuser == KIND_QUERY) begin
          state_next = (wall_count == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: state_next = ST_AXIS;
      ST_AXIS: begin
        if (ax_d == '0) begin
          if (!in_slab) begin
            state_next = last_wall ? ST_DONE : ST_READ;
          end else if (ax == 2'd2) begin
            state_next = ST_FIN;
          end
        end else begin
          div_start  = 1'b1;
          state_next = ST_DLO;
        end
      end
      ST_DLO: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_DHI;
        end
      end
      ST_DHI: begin
        if (div_done) begin
          state_next = ST_COMB;
        end
      end
      ST_COMB: begin
        if (rej) begin
          state_next = last_wall ? ST_DONE : ST_READ;
        end else begin
          state_next = (ax == 2'd2) ? ST_FIN : ST_AXIS;
        end
      end
      ST_FIN: begin
        if (hit || last_wall) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      wall <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && s_tuser == KIND_QUERY) begin
            org[0] <= s_tdata[37:6];
            org[1] <= s_tdata[69:38];
            org[2] <= s_tdata[101:70];
            dir[0] <= DIFF_BITS'($signed(s_tdata[133:102]))
                    - DIFF_BITS'($signed(s_tdata[37:6]));
            dir[1] <= DIFF_BITS'($signed(s_tdata[165:134]))
                    - DIFF_BITS'($signed(s_tdata[69:38]));
            dir[2] <= DIFF_BITS'($signed(s_tdata[197:166]))
                    - DIFF_BITS'($signed(s_tdata[101:70]));
            num_walls <= (wall_count > CNT_BITS'(MAX_WALLS)) ? CNT_BITS'(MAX_WALLS)
                                                             : wall_count;
            wall      <= '0;
            res_clear <= 1'b1;
            res_wall  <= '0;
          end
        end
        ST_READ: begin
          ax     <= 2'd0;
          run_lo <= T_NEG_INF;
          run_hi <= T_POS_INF;
        end
        ST_AXIS: begin
          n_far <= n_hi;
          if (ax_d == '0) begin
            if (!in_slab) begin
              wall <= wall + 1'b1;
            end else begin
              ax <= ax + 1'b1;
            end
          end
        end
        ST_DLO: begin
          if (div_done) begin
            t_lo <= div_q;
          end
        end
        ST_DHI: begin
          if (div_done) begin
            t_hi <= div_q;
          end
        end
        ST_COMB: begin
          if (rej) begin
            wall <= wall + 1'b1;
          end else begin
            run_lo <= (t_lo > run_lo) ? t_lo : run_lo;
            run_hi <= (t_hi < run_hi) ? t_hi : run_hi;
            ax     <= ax + 1'b1;
          end
        end
        ST_FIN: begin
          if (hit) begin
            res_clear <= 1'b0;
            res_wall  <= wall;
          end else begin
            wall <= wall + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {1'b0, res_wall, res_clear};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sbl_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module sbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/core/sbl_div.sv @@
// shared restoring divider, one quotient bit per cycle, forms (num << 16) / den
`default_nettype none
module sbl_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [sbl_pkg::DIFF_BITS-1:0] num,
  input  wire logic [sbl_pkg::DIFF_BITS-1:0] den,
  input  wire logic                         neg,
  output logic                              done,
  output logic signed [sbl_pkg::T_BITS-1:0] quot
);
  import sbl_pkg::*;

  logic                  busy;
  logic [STEP_BITS-1:0]  cnt;
  logic [DIFF_BITS-1:0]  rem;
  logic [DVD_BITS-1:0]   dvd;
  logic                  neg_q;
  logic [DIFF_BITS:0]    shifted;
  logic                  take;
  logic [DIFF_BITS:0]    diff;
  logic [T_BITS-1:0]     mag;

  // one restoring step
  always_comb begin
    shifted = {rem, dvd[DVD_BITS-1]};
    diff    = shifted - {1'b0, den};
    take    = (shifted >= {1'b0, den});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_BITS'(DVD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dvd   <= {num, {FRAC_BITS{1'b0}}};
      neg_q <= neg;
    end else if (busy) begin
      rem <= take ? diff[DIFF_BITS-1:0] : shifted[DIFF_BITS-1:0];
      dvd <= {dvd[DVD_BITS-2:0], take};
    end
  end

  // signed result
  always_comb begin
    mag  = T_BITS'(dvd);
    quot = neg_q ? -$signed(mag) : $signed(mag);
  end

endmodule
`default_nettype wire

@@ sim/sbl_checker.sv @@
// checker for segment_box_line_of_sight: wall table mirror, slab test prediction, result compare
`default_nettype none
module sbl_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [199:0] s_tdata,
  input  wire logic         s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [7:0]   m_tdata,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [16:0]  cfg_data,
  output int                fail_count,
  output int                pending,
  output int                loads_seen,
  output int                results_seen,
  output int                blocked_seen
);
  import sbl_pkg::*;

  // same bit order as m_tdata: line_clear in the lowest bit
  typedef struct packed {
    logic [5:0] wall;
    logic       clear;
  } sight_t;

  sight_t      sight_q[$];
  longint      box_lo[0:MAX_WALLS-1][0:2];
  longint      box_hi[0:MAX_WALLS-1][0:2];
  longint      seg_org[0:2];
  longint      seg_dir[0:2];
  logic [6:0]  walls_tested;
  logic [16:0] near_t;
  logic [16:0] far_t;

  assign pending = sight_q.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // entry and exit parameter of the segment on one axis; zero if a flat axis misses
  function automatic bit axis_interval(input longint o, input longint d, input longint mn,
                                       input longint mx, output longint lo, output longint hi);
    longint near_face;
    longint far_face;
    if (d == 0) begin
      lo = T_NEG_INF;
      hi = T_POS_INF;
      return (mn <= o) && (o <= mx);
    end
    near_face = (d > 0) ? mn : mx;
    far_face  = (d > 0) ? mx : mn;
    // division truncates toward zero, as the block's divider does
    lo = ((near_face - o) * 65536) / d;
    hi = ((far_face - o) * 65536) / d;
    return 1'b1;
  endfunction

  // slab test of the current segment against one table entry
  function automatic bit wall_blocks(input int w);
    longint lo, hi, alo, ahi;
    bit     ok;
    ok = axis_interval(seg_org[0], seg_dir[0], box_lo[w][0], box_hi[w][0], lo, hi);
    for (int ax = 1; ax < 3; ax++) begin
      ok &= axis_interval(seg_org[ax], seg_dir[ax], box_lo[w][ax], box_hi[w][ax], alo, ahi);
      if (!ok) return 1'b0;
      if (lo > ahi || alo > hi) return 1'b0;
      if (alo > lo) lo = alo;
      if (ahi < hi) hi = ahi;
    end
    if (!ok) return 1'b0;
    return (lo < longint'(far_t)) && (hi > longint'(near_t));
  endfunction

  function automatic sight_t predict_sight();
    sight_t r;
    int     n;
    n = (walls_tested > MAX_WALLS) ? MAX_WALLS : int'(walls_tested);
    r.clear = 1'b1;
    r.wall  = '0;
    for (int w = 0; w < n; w++) begin
      if (wall_blocks(w)) begin
        r.clear = 1'b0;
        r.wall  = w[5:0];
        return r;
      end
    end
    return r;
  endfunction

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    sight_t got;
    sight_t want;
    int     slot;
    if (rst) begin
      sight_q.delete();
      walls_tested = '0;
      near_t       = '0;
      far_t        = 17'd65535;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WALL_COUNT: walls_tested = cfg_data[6:0];
          CFG_NEAR_LIMIT: near_t = cfg_data;
          CFG_FAR_LIMIT:  far_t = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        slot = int'(s_tdata[5:0]);
        if (s_tuser == KIND_LOAD) begin
          for (int ax = 0; ax < 3; ax++) begin
            box_lo[slot][ax] = longint'($signed(s_tdata[6 + 32*ax +: 32]));
            box_hi[slot][ax] = longint'($signed(s_tdata[102 + 32*ax +: 32]));
          end
          loads_seen++;
        end else begin
          for (int ax = 0; ax < 3; ax++) begin
            seg_org[ax] = longint'($signed(s_tdata[6 + 32*ax +: 32]));
            seg_dir[ax] = longint'($signed(s_tdata[102 + 32*ax +: 32])) - seg_org[ax];
          end
          sight_q.push_back(predict_sight());
        end
      end
      if (m_tvalid && m_tready) begin
        got = sight_t'(m_tdata[6:0]);
        results_seen++;
        if (!got.clear) blocked_seen++;
        if (sight_q.size() == 0) begin
          report("result item with nothing expected, line_clear", got.clear, 0);
        end else begin
          want = sight_q.pop_front();
          if (got.clear !== want.clear) report("line_clear", got.clear, want.clear);
          if (got.wall !== want.wall) report("blocking_wall", got.wall, want.wall);
          if (m_tdata[7] !== 1'b0) report("pad bit", m_tdata[7], 0);
        end
      end
    end
  end

  initial begin
    fail_count   = 0;
    loads_seen   = 0;
    results_seen = 0;
    blocked_seen = 0;
  end

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// testbench top for segment_box_line_of_sight: stimulus, handshake idling and verdict
`default_nettype none
module tb_top;
  import sbl_pkg::*;

  localparam int CYCLE_LIMIT = 30_000_000;
  localparam int UNIT        = 65536;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // [5:0] wall_slot, [101:6] a_x a_y a_z, [197:102] b_x b_y b_z, [199:198] zero
  logic [199:0] s_tdata;
  // [0] kind
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  // [0] line_clear, [6:1] blocking_wall, [7] zero
  logic [7:0]   m_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [16:0]  cfg_data;

  int  fail_count, pending, loads_seen, results_seen, blocked_seen;
  int  cycles;
  int  stall_left;
  bit  quiet;

  segment_box_line_of_sight u_dut (.*);

  sbl_checker u_chk (.*);

  // clock and cycle limit
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("segment_box_line_of_sight test failed");
      $finish;
    end
  end

  // receiver with random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready = 1'b0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  task automatic send_item(input logic kind, input logic [5:0] slot,
                           input logic [2:0][31:0] a, input logic [2:0][31:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tuser  = kind;
    s_tdata  = {2'b00, b, a, slot};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // register write once every expected result is back
  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] near_coord(input int span_units);
    return 32'($urandom_range(0, 2 * span_units * UNIT)) - 32'(span_units * UNIT);
  endfunction

  function automatic logic [31:0] units(input int u);
    return 32'(u * UNIT);
  endfunction

  task automatic load_random_box(input logic [5:0] slot);
    logic [2:0][31:0] lo, hi;
    for (int ax = 0; ax < 3; ax++) begin
      lo[ax] = near_coord(150);
      hi[ax] = lo[ax] + 32'($urandom_range(0, 60 * UNIT));
    end
    // occasional inverted or raw random boxes
    if ($urandom_range(0, 19) == 0) send_item(KIND_LOAD, slot, hi, lo);
    else if ($urandom_range(0, 19) == 0)
      send_item(KIND_LOAD, slot, {$urandom, $urandom, $urandom}, {$urandom, $urandom, $urandom});
    else send_item(KIND_LOAD, slot, lo, hi);
  endtask

  task automatic query_random();
    logic [2:0][31:0] a, b;
    for (int ax = 0; ax < 3; ax++) begin
      a[ax] = near_coord(200);
      b[ax] = near_coord(200);
    end
    // flat axes and raw noise now and then
    if ($urandom_range(0, 5) == 0) b[$urandom_range(0, 2)] = a[0];
    if ($urandom_range(0, 7) == 0) begin
      b[0] = a[0];
      b[1] = a[1];
    end
    if ($urandom_range(0, 9) == 0) begin
      a = {$urandom, $urandom, $urandom};
      b = {$urandom, $urandom, $urandom};
    end
    send_item(KIND_QUERY, 6'($urandom), a, b);
  endtask

  task automatic query(input int ax, input int ay, input int az,
                       input int bx, input int by, input int bz);
    send_item(KIND_QUERY, 6'd0, {units(az), units(ay), units(ax)},
              {units(bz), units(by), units(bx)});
  endtask

  initial begin
    logic [16:0] nl, fl;
    int          nq;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = KIND_LOAD;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_WALL_COUNT;
    cfg_data   = '0;
    m_tready   = 1'b0;
    stall_left = 0;
    quiet      = 1'b0;
    cycles     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill the whole table so no query reads an unwritten entry
    for (int w = 0; w < MAX_WALLS; w++) load_random_box(6'(w));

    // directed: wall 0 is the box 0..10 on all axes, wall 1 spans everything
    send_item(KIND_LOAD, 6'd0, '0, {units(10), units(10), units(10)});
    send_item(KIND_LOAD, 6'd1, {3{32'h8000_0000}}, {3{32'h7fff_ffff}});
    query(-5, 5, 5, 15, 5, 5);
    write_reg(CFG_WALL_COUNT, 17'd1);
    query(-5, 5, 5, 15, 5, 5);
    query(15, 5, 5, -5, 5, 5);
    query(-5, 20, 5, 15, 20, 5);
    query(-5, 10, 5, 15, 10, 5);
    query(-5, 0, 0, 15, 0, 0);
    query(-5, 11, 5, 15, 11, 5);
    query(5, 5, 5, 5, 5, 5);
    query(20, 20, 20, 20, 20, 20);
    query(-20, 5, 5, -15, 5, 5);
    send_item(KIND_QUERY, 6'h3f, {3{32'h8000_0000}}, {3{32'h7fff_ffff}});
    send_item(KIND_QUERY, 6'h2a, {3{32'h7fff_ffff}}, {3{32'h8000_0000}});
    write_reg(CFG_WALL_COUNT, 17'd2);
    query(30, 30, 30, 40, 40, 40);
    write_reg(CFG_NEAR_LIMIT, 17'd65536);
    write_reg(CFG_FAR_LIMIT, 17'd65536);
    query(-5, 5, 5, 15, 5, 5);
    write_reg(CFG_NEAR_LIMIT, 17'd0);
    write_reg(CFG_FAR_LIMIT, 17'd0);
    query(-5, 5, 5, 15, 5, 5);
    query(5, 5, 5, 15, 5, 5);
    write_reg(CFG_WALL_COUNT, 17'd0);
    query(-5, 5, 5, 15, 5, 5);
    write_reg(CFG_WALL_COUNT, 17'd127);
    query(300, 300, 300, 310, 310, 310);
    write_reg(CFG_WALL_COUNT, 17'd64);
    query_random();

    // random phases, each with its own register settings
    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph >= 10);
      case ($urandom_range(0, 3))
        0: nl = 17'd0;
        1: nl = 17'd65536;
        default: nl = 17'($urandom_range(0, 20000));
      endcase
      case ($urandom_range(0, 3))
        0: fl = 17'd65536;
        1: fl = 17'd65535;
        default: fl = 17'($urandom_range(30000, 65536));
      endcase
      write_reg(CFG_NEAR_LIMIT, nl);
      write_reg(CFG_FAR_LIMIT, fl);
      write_reg(CFG_WALL_COUNT, 17'((ph == 5) ? 64 : $urandom_range(1, 4)));
      nq = (ph == 5) ? 4 : 145;
      for (int i = 0; i < nq; i++) begin
        if ($urandom_range(0, 9) < 4) load_random_box(6'($urandom));
        else query_random();
      end
    end
    s_tvalid = 1'b0;

    // drain and settle
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("covered %0d wall loads and %0d queries, %0d of them blocked",
             loads_seen, results_seen, blocked_seen);
    $display("registers swept through count, near and far window extremes");
    if (fail_count == 0 && pending == 0) begin
      $display("segment_box_line_of_sight test passed");
    end else begin
      $display("segment_box_line_of_sight test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/core/sbl_pkg.sv
rtl/core/sbl_ram.sv
rtl/core/sbl_div.sv
rtl/core/segment_box_line_of_sight.sv
sim/sbl_checker.sv
sim/tb_top.sv
